// ----- design/asfdo_pkg.sv -----
package asfdo_pkg;

    // Sample and field widths
    localparam int SAMPLE_BITS = 24;
    localparam int LEVEL_W     = 17;
    localparam int LIMIT_W     = 17;
    localparam int FMT_W       = 2;
    localparam int DEPTH_DEF   = 65536;
    localparam int RING_LIMIT_RST = 65536;

    // Q2.22 unity and int16 scale
    localparam int ONE_Q_INT   = 1 << (SAMPLE_BITS - 2);
    localparam int SCALE_INT   = 32767;
    localparam int PROD_W      = SAMPLE_BITS + 16;

    // APB
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;

    // Commands
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_PULL  = 1'b1;

    // Register index (paddr[2])
    localparam logic REG_OUT_FORMAT = 1'b0;
    localparam logic REG_RING_LIMIT = 1'b1;

    // Output formats
    localparam logic [FMT_W-1:0] FMT_PASS  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_INT16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_ZERO  = 2'd2;

    // Sideband carried alongside a pulled sample
    typedef struct packed {
        logic               underrun;
        logic [LEVEL_W-1:0] fill;
    } t_tag;

endpackage

// ----- design/asfdo_conv.sv -----
module asfdo_conv (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [asfdo_pkg::FMT_W-1:0]          i_fmt,
    input  logic signed [asfdo_pkg::SAMPLE_BITS-1:0] i_sample,
    input  asfdo_pkg::t_tag                      i_tag,
    output logic                                 o_busy,
    output logic                                 o_valid,
    output logic signed [asfdo_pkg::SAMPLE_BITS-1:0] o_sample,
    output asfdo_pkg::t_tag                      o_tag
);
    import asfdo_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] ONE_Q     = SAMPLE_BITS'(ONE_Q_INT);
    localparam logic signed [SAMPLE_BITS-1:0] NEG_ONE_Q = -ONE_Q;
    localparam logic signed [PROD_W-1:0]      SCALE     = PROD_W'(SCALE_INT);
    localparam logic signed [PROD_W-1:0]      BIAS      = PROD_W'(ONE_Q_INT - 1);

    // stage 1: clamp and multiply
    logic                            r_v1;
    logic [FMT_W-1:0]                r_kind;
    logic signed [SAMPLE_BITS-1:0]   r_raw;
    logic signed [PROD_W-1:0]        r_prod;
    t_tag                            r_tag1;

    logic signed [SAMPLE_BITS-1:0]   w_clamp;
    logic [FMT_W-1:0]                w_kind;

    always_comb begin
        if (i_sample > ONE_Q) begin
            w_clamp = ONE_Q;
        end else if (i_sample < NEG_ONE_Q) begin
            w_clamp = NEG_ONE_Q;
        end else begin
            w_clamp = i_sample;
        end
        // empty store or silence formats give zero
        if (i_tag.underrun) begin
            w_kind = FMT_ZERO;
        end else begin
            case (i_fmt)
                FMT_PASS:  w_kind = FMT_PASS;
                FMT_INT16: w_kind = FMT_INT16;
                default:   w_kind = FMT_ZERO;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_kind <= w_kind;
            r_raw  <= i_sample;
            r_prod <= PROD_W'(w_clamp) * SCALE;
            r_tag1 <= i_tag;
        end
    end

    // stage 2: divide by unity, truncating toward zero
    logic signed [PROD_W-1:0]      w_sum;
    logic signed [PROD_W-1:0]      w_quo;
    logic signed [SAMPLE_BITS-1:0] w_res;

    always_comb begin
        w_sum = r_prod + (r_prod[PROD_W-1] ? BIAS : '0);
        w_quo = w_sum >>> (SAMPLE_BITS - 2);
        case (r_kind)
            FMT_PASS:  w_res = r_raw;
            FMT_INT16: w_res = SAMPLE_BITS'(w_quo);
            default:   w_res = '0;
        endcase
    end

    logic                          r_v2;
    logic signed [SAMPLE_BITS-1:0] r_out;
    t_tag                          r_tag2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_out  <= w_res;
            r_tag2 <= r_tag1;
        end
    end

    assign o_busy   = r_v1;
    assign o_valid  = r_v2;
    assign o_sample = r_out;
    assign o_tag    = r_tag2;

endmodule

// ----- design/audio_sample_fifo_drop_oldest_top.sv -----
// Audio sample FIFO with drop-oldest overflow and optional int16 output.
//
// Command channel: a beat is taken on a clock edge with start high and busy
// low. i_cmd selects push (store i_sample_in, Q2.22) or pull (pop oldest).
// A push that finds ring_limit samples held first drops the oldest ones.
// Result channel: each pull yields one beat, o_valid high for one cycle with
// o_sample_out, o_underrun and o_fill_level. The receiver cannot stall; a
// beat not taken in its cycle is gone. Pushes give no result.
//
// A push raises no busy, so the next beat may follow straight after it.
// A pull reads the sample memory into a register, then clamps and
// multiplies (one register), then scales into the output register as
// o_valid rises. busy is high while the pull is in the read register or
// the multiply register, so a new beat is taken only once the pull has
// reached the output register. Those two registers set the wait.
//
// Reset (synchronous, i_rst_n low) empties the FIFO and restores out_format
// and ring_limit; the sample memory is not cleared, since entries are used
// only after being written. Registers go through APB (out_format at 0x0,
// ring_limit at 0x4), written by the user only while idle (not enforced).
module audio_sample_fifo_drop_oldest_top #(
    parameter int DEPTH = asfdo_pkg::DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // command channel
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    i_cmd,
    input  logic signed [asfdo_pkg::SAMPLE_BITS-1:0] i_sample_in,
    // result channel
    output logic                                    o_valid,
    output logic signed [asfdo_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                    o_underrun,
    output logic [asfdo_pkg::LEVEL_W-1:0]           o_fill_level,
    // APB config
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [asfdo_pkg::APB_AW-1:0]            paddr,
    input  logic [asfdo_pkg::APB_DW-1:0]            pwdata,
    output logic [asfdo_pkg::APB_DW-1:0]            prdata,
    output logic                                    pready
);
    import asfdo_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int HW = $clog2(DEPTH + 1);
    localparam int LIM_RST_EFF = (RING_LIMIT_RST > DEPTH) ? DEPTH : RING_LIMIT_RST;

    // ---------------------------------------------------------------
    // Config registers. r_lim_m1 holds the effective limit minus one,
    // with zero taken as one and anything above DEPTH taken as DEPTH.
    // ---------------------------------------------------------------
    logic [FMT_W-1:0]   r_out_format;
    logic [LIMIT_W-1:0] r_ring_limit;
    logic [AW-1:0]      r_lim_m1;

    logic               w_cfg_wr;
    logic [31:0]        w_lim32;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        w_lim32 = 32'(pwdata[LIMIT_W-1:0]);
        if (w_lim32 == 32'd0) begin
            w_lim32 = 32'd1;
        end else if (w_lim32 > 32'(DEPTH)) begin
            w_lim32 = 32'(DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_format <= FMT_PASS;
            r_ring_limit <= LIMIT_W'(RING_LIMIT_RST);
            r_lim_m1     <= AW'(LIM_RST_EFF - 1);
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_OUT_FORMAT: begin
                    r_out_format <= pwdata[FMT_W-1:0];
                end
                REG_RING_LIMIT: begin
                    r_ring_limit <= pwdata[LIMIT_W-1:0];
                    r_lim_m1     <= AW'(w_lim32 - 32'd1);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_OUT_FORMAT: prdata = APB_DW'(r_out_format);
            REG_RING_LIMIT: prdata = APB_DW'(r_ring_limit);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // FIFO control
    // ---------------------------------------------------------------
    logic [AW-1:0] r_rp;
    logic [AW-1:0] r_wp;
    logic [HW-1:0] r_held;

    logic          w_take;
    logic          w_push;
    logic          w_pull;
    logic          w_empty;
    logic          w_conv_busy;

    assign w_take  = start && !busy;
    assign w_push  = w_take && (i_cmd == CMD_PUSH);
    assign w_pull  = w_take && (i_cmd == CMD_PULL);
    assign w_empty = (r_held == '0);

    logic [AW-1:0] w_rp_inc;
    logic [AW-1:0] w_wp_inc;
    logic [AW:0]   w_diff;
    logic [AW-1:0] w_rp_drop;
    logic          w_full;

    assign w_rp_inc = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
    assign w_wp_inc = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
    // held >= limit: oldest entries go so that limit-1 remain
    assign w_full   = (r_held > HW'(r_lim_m1));
    assign w_diff   = {1'b0, r_wp} - {1'b0, r_lim_m1};
    assign w_rp_drop = w_diff[AW] ? AW'(w_diff + (AW + 1)'(DEPTH)) : w_diff[AW-1:0];

    logic [AW-1:0] n_rp;
    logic [AW-1:0] n_wp;
    logic [HW-1:0] n_held;

    always_comb begin
        n_rp   = r_rp;
        n_wp   = r_wp;
        n_held = r_held;
        if (w_push) begin
            n_wp = w_wp_inc;
            if (w_full) begin
                n_rp   = w_rp_drop;
                n_held = HW'(r_lim_m1) + HW'(1);
            end else begin
                n_held = r_held + HW'(1);
            end
        end else if (w_pull && !w_empty) begin
            n_rp   = w_rp_inc;
            n_held = r_held - HW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_wp   <= '0;
            r_held <= '0;
        end else begin
            r_rp   <= n_rp;
            r_wp   <= n_wp;
            r_held <= n_held;
        end
    end

    // ---------------------------------------------------------------
    // Sample memory: one write port, one registered read port.
    // A push retires before any pull can read, so no forwarding needed.
    // ---------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_sample_in;
        end
        if (w_pull) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    // read stage: tag rides with the memory data
    logic r_rd_v;
    t_tag r_rd_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= w_pull;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pull) begin
            r_rd_tag.underrun <= w_empty;
            r_rd_tag.fill     <= LEVEL_W'(n_held);
        end
    end

    assign busy = r_rd_v || w_conv_busy;

    t_tag w_out_tag;

    asfdo_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_v),
        .i_fmt    (r_out_format),
        .i_sample ($signed(r_rd_data)),
        .i_tag    (r_rd_tag),
        .o_busy   (w_conv_busy),
        .o_valid  (o_valid),
        .o_sample (o_sample_out),
        .o_tag    (w_out_tag)
    );

    assign o_underrun   = w_out_tag.underrun;
    assign o_fill_level = w_out_tag.fill;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(DEPTH))
        else $error("held count above depth");

    a_ptr_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held == '0 || r_held == HW'(DEPTH)) |-> (r_rp == r_wp))
        else $error("pointers disagree with held count");

    a_pull_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pull |-> ##3 o_valid)
        else $error("pull gave no result beat");

    a_underrun_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_underrun) |-> (o_sample_out == '0 && o_fill_level == '0))
        else $error("underrun beat not zero");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pull |=> busy)
        else $error("busy low while pull in flight");

endmodule
